/* sv/stq_pkg.sv */
// Shared types and constants for the sorted timer queue.
package stq_pkg;

    localparam int DEF_NUM_TIMERS = 16;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [4:0] TASK_NONE = 5'd16;

    typedef enum logic [2:0] {
        ACT_ALLOC  = 3'd0,
        ACT_FREE   = 3'd1,
        ACT_LOAD   = 3'd2,
        ACT_START  = 3'd3,
        ACT_TICK   = 3'd4,
        ACT_REBASE = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        KIND_ALLOC   = 3'd0,
        KIND_NO_SLOT = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_EXPIRED = 3'd3,
        KIND_TICKED  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_POP,
        CELL_REBASE,
        CELL_FREE
    } t_cell_op;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op    op;
        logic [31:0] key;
        logic [31:0] base;
    } t_cell_ctrl;

endpackage

/* sv/stq_cell.sv */
// One position of the ordered timer row: slot number, expiry and flags.
module stq_cell #(
    parameter int SLOT_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stq_pkg::t_cell_ctrl i_ctrl,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic                i_left_v,
    input  logic                i_left_r,
    input  logic [SLOT_W-1:0]   i_left_s,
    input  logic [31:0]         i_left_e,
    input  logic                i_right_v,
    input  logic                i_right_r,
    input  logic [SLOT_W-1:0]   i_right_s,
    input  logic [31:0]         i_right_e,
    input  logic                i_chain,
    output logic                o_v,
    output logic                o_r,
    output logic [SLOT_W-1:0]   o_s,
    output logic [31:0]         o_e,
    output logic                o_chain
);
    import stq_pkg::*;

    logic              r_v, r_r;
    logic [SLOT_W-1:0] r_s;
    logic [31:0]       r_e;
    logic              n_v, n_r;
    logic [SLOT_W-1:0] n_s;
    logic [31:0]       n_e;
    logic              match;
    logic              fits;

    assign match = r_v && (r_s == i_slot);
    assign fits  = !r_v || (i_ctrl.key <= r_e);

    // Remove and insert: a cell shifts by its left neighbor's chain flag (on remove, also by its own match).
    always_comb begin
        n_v     = r_v;
        n_r     = r_r;
        n_s     = r_s;
        n_e     = r_e;
        o_chain = 1'b0;
        unique case (i_ctrl.op)
            CELL_REMOVE: begin
                o_chain = i_chain || match;
                if (o_chain) begin
                    n_v = i_right_v;
                    n_r = i_right_r;
                    n_s = i_right_s;
                    n_e = i_right_e;
                end
            end
            CELL_INSERT: begin
                o_chain = i_chain || fits;
                if (i_chain) begin
                    n_v = i_left_v;
                    n_r = i_left_r;
                    n_s = i_left_s;
                    n_e = i_left_e;
                end else if (fits) begin
                    n_v = 1'b1;
                    n_r = 1'b1;
                    n_s = i_slot;
                    n_e = i_ctrl.key;
                end
            end
            CELL_POP: begin
                n_v = i_right_v;
                n_r = i_right_r;
                n_s = i_right_s;
                n_e = i_right_e;
            end
            CELL_REBASE: begin
                if (r_v && r_r && (r_e != ALL_ONES)) begin
                    n_e = r_e - i_ctrl.base;
                end
            end
            CELL_FREE: begin
                if (match) begin
                    n_r = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
            r_r <= 1'b0;
        end else begin
            r_v <= n_v;
            r_r <= n_r;
        end
        r_s <= n_s;
        r_e <= n_e;
    end

    assign o_v = r_v;
    assign o_r = r_r;
    assign o_s = r_s;
    assign o_e = r_e;

endmodule

/* sv/sorted_timer_queue_top.sv */
// Top level of the sorted timer queue: sequencer, slot stores and the cell row.
// Allocate, free, load and rebase give their result at once; start runs through
// its steps (take the slot out of the row, insert it at its place, reply); a
// tick pops one expired timer per cycle while the output is free, then gives
// the final result. The row of cells holds the running order, earliest first,
// and shifts as a whole, so no operation walks the slots.
// Results stall while the output is not taken.
module sorted_timer_queue_top #(
    parameter int NUM_TIMERS = stq_pkg::DEF_NUM_TIMERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_timer_id,
    input  logic [7:0]  i_destination,
    input  logic [31:0] i_data_word,
    input  logic [31:0] i_delay,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic [7:0]  o_out_destination,
    output logic [31:0] o_out_data,
    output logic        o_switch_task,
    output logic        o_last
);
    import stq_pkg::*;

    localparam int SLOT_W = $clog2(NUM_TIMERS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REMOVE = 5'b00010,
        ST_INSERT = 5'b00100,
        ST_REPLY  = 5'b01000,
        ST_POP    = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [31:0]       r_cnt;
    logic [4:0]        r_task;
    logic [NUM_TIMERS-1:0] r_used;
    logic [SLOT_W-1:0] r_slot;
    logic [31:0]       r_key;
    logic              r_sw;
    logic [7:0]        r_chan [NUM_TIMERS];
    logic [31:0]       r_word [NUM_TIMERS];

    logic              r_ov;
    t_kind             r_kind;
    logic [SLOT_W-1:0] r_oslot;
    logic [7:0]        r_odest;
    logic [31:0]       r_odata;
    logic              r_osw;
    logic              r_olast;

    logic              c_v [NUM_TIMERS];
    logic              c_r [NUM_TIMERS];
    logic [SLOT_W-1:0] c_s [NUM_TIMERS];
    logic [31:0]       c_e [NUM_TIMERS];
    logic              chain [NUM_TIMERS+1];

    t_cell_ctrl        ctrl;
    logic              out_free;
    logic              accept;
    logic              id_ok;
    logic [SLOT_W-1:0] id;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              pop_now;
    logic              head_task;
    logic              emit;
    t_kind             e_kind;
    logic [SLOT_W-1:0] e_slot;
    logic [7:0]        e_dest;
    logic [31:0]       e_data;
    logic              e_sw;
    logic              e_last;

    assign out_free   = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign id_ok      = 32'(i_timer_id) < NUM_TIMERS;
    assign id         = SLOT_W'(i_timer_id);
    assign pop_now    = c_v[0] && (c_e[0] <= r_cnt);
    assign head_task  = (32'(c_s[0]) == 32'(r_task));

    // Lowest unused slot for allocation.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Sequencer: row command, next state and the result to emit.
    always_comb begin
        n_state   = r_state;
        ctrl.op   = CELL_HOLD;
        ctrl.key  = r_key;
        ctrl.base = r_cnt;
        emit      = 1'b0;
        e_kind    = KIND_DONE;
        e_slot    = '0;
        e_dest    = '0;
        e_data    = '0;
        e_sw      = 1'b0;
        e_last    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_action == ACT_ALLOC) begin
                        emit   = 1'b1;
                        e_kind = free_found ? KIND_ALLOC : KIND_NO_SLOT;
                        e_slot = free_found ? free_idx : '0;
                    end else if (i_action == ACT_TICK) begin
                        n_state = ST_POP;
                    end else if (i_action == ACT_REBASE) begin
                        ctrl.op = CELL_REBASE;
                        emit    = 1'b1;
                    end else if (i_action == ACT_START && id_ok) begin
                        n_state = ST_REMOVE;
                    end else begin
                        if (i_action == ACT_FREE && id_ok) begin
                            ctrl.op = CELL_FREE;
                        end
                        emit = 1'b1;
                    end
                end
            end
            ST_REMOVE: begin
                ctrl.op = CELL_REMOVE;
                n_state = ST_INSERT;
            end
            ST_INSERT: begin
                ctrl.op = CELL_INSERT;
                n_state = ST_REPLY;
            end
            ST_REPLY: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_POP: begin
                if (out_free) begin
                    if (pop_now) begin
                        ctrl.op = CELL_POP;
                        emit    = !head_task;
                        e_kind  = KIND_EXPIRED;
                        e_slot  = c_s[0];
                        e_dest  = r_chan[c_s[0]];
                        e_data  = r_word[c_s[0]];
                        e_last  = 1'b0;
                    end else begin
                        emit    = 1'b1;
                        e_kind  = KIND_TICKED;
                        e_sw    = r_sw;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, tick count and slot status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_task  <= TASK_NONE;
            r_used  <= '0;
            r_sw    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_task <= i_cfg_data;
            end
            if (out_free) begin
                r_ov <= emit;
            end
            if (accept) begin
                r_sw <= 1'b0;
                if (i_action == ACT_TICK) begin
                    r_cnt <= r_cnt + 32'd1;
                end else if (i_action == ACT_REBASE) begin
                    r_cnt <= '0;
                end
                if (i_action == ACT_ALLOC && free_found) begin
                    r_used[free_idx] <= 1'b1;
                end else if (i_action == ACT_FREE && id_ok) begin
                    r_used[id] <= 1'b0;
                end else if (i_action == ACT_START && id_ok) begin
                    r_used[id] <= 1'b1;
                end
            end
            if (ctrl.op == CELL_POP) begin
                r_used[c_s[0]] <= 1'b1;
                if (head_task) begin
                    r_sw <= 1'b1;
                end
            end
        end
    end

    // Request fields kept for the start sequence, slot payload stores, result register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot <= id;
            r_key  <= i_delay + r_cnt;
            if (i_action == ACT_LOAD && id_ok) begin
                r_chan[id] <= i_destination;
                r_word[id] <= i_data_word;
            end
        end
        if (emit) begin
            r_kind  <= e_kind;
            r_oslot <= e_slot;
            r_odest <= e_dest;
            r_odata <= e_data;
            r_osw   <= e_sw;
            r_olast <= e_last;
        end
    end

    // Row of cells, earliest expiry at position zero.
    assign chain[0] = 1'b0;
    for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
        logic              lv, lr, rv, rr;
        logic [SLOT_W-1:0] ls, rs;
        logic [31:0]       le, re;
        if (i == 0) begin : g_first
            assign lv = 1'b0;
            assign lr = 1'b0;
            assign ls = '0;
            assign le = '0;
        end else begin : g_mid
            assign lv = c_v[i-1];
            assign lr = c_r[i-1];
            assign ls = c_s[i-1];
            assign le = c_e[i-1];
        end
        if (i == NUM_TIMERS - 1) begin : g_last
            assign rv = 1'b0;
            assign rr = 1'b0;
            assign rs = '0;
            assign re = '0;
        end else begin : g_next
            assign rv = c_v[i+1];
            assign rr = c_r[i+1];
            assign rs = c_s[i+1];
            assign re = c_e[i+1];
        end
        stq_cell #(.SLOT_W(SLOT_W)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_slot   (r_state == ST_IDLE ? id : r_slot),
            .i_left_v (lv),
            .i_left_r (lr),
            .i_left_s (ls),
            .i_left_e (le),
            .i_right_v(rv),
            .i_right_r(rr),
            .i_right_s(rs),
            .i_right_e(re),
            .i_chain  (chain[i]),
            .o_v      (c_v[i]),
            .o_r      (c_r[i]),
            .o_s      (c_s[i]),
            .o_e      (c_e[i]),
            .o_chain  (chain[i+1])
        );
    end

    assign o_out_valid       = r_ov;
    assign o_kind            = r_kind;
    assign o_slot            = 4'(r_oslot);
    assign o_out_destination = r_odest;
    assign o_out_data        = r_odata;
    assign o_switch_task     = r_osw;
    assign o_last            = r_olast;

endmodule
